@@ rtl/rth_pkg.sv @@
// Shared types, constants and fixed-point helpers for the ray/triangle hit test.
// Depends on nothing.
`default_nettype none
package rth_pkg;
   localparam int W = 64;
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [W-1:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   function automatic logic signed [W-1:0] sadd(logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] ssub(logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
      return s[W-1:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/rth_mul.sv @@
// Pipelined saturating fixed-point multiplier: 64x64 split into 32-bit partial
// products over three stages. Uses rth_pkg.
`default_nettype none
module rth_mul #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic signed [rth_pkg::W-1:0] a,
   input  wire logic signed [rth_pkg::W-1:0] b,
   output logic signed [rth_pkg::W-1:0]      p
);
   import rth_pkg::*;
   logic [W-1:0] ma, mb;
   logic         neg_ff, neg2_ff;
   logic [W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] full_ff, full_in, sh;
   logic signed [W-1:0] p_ff, p_in;

   always_comb begin
      ma = a[W-1] ? (~a + 64'd1) : a;
      mb = b[W-1] ? (~b + 64'd1) : b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= a[W-1] ^ b[W-1];
         p00_ff <= ma[31:0] * mb[31:0];
         p01_ff <= ma[31:0] * mb[63:32];
         p10_ff <= ma[63:32] * mb[31:0];
         p11_ff <= ma[63:32] * mb[63:32];
      end
   end

   always_comb
      full_in = {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
              + {p11_ff, 64'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         full_ff <= full_in;
         neg2_ff <= neg_ff;
      end
   end

   always_comb begin
      sh = full_ff >> FRAC_BITS;
      if (!neg2_ff) p_in = (sh[127:63] != '0) ? SMAX : sh[63:0];
      else p_in = (sh[127:64] != '0 || sh[63]) ? SMIN : (~sh[63:0] + 64'd1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end
   assign p = p_ff;
endmodule
`default_nettype wire

@@ rtl/rth_div.sv @@
// Pipelined saturating fixed-point divider, one quotient bit per stage,
// with side data carried alongside. Uses rth_pkg.
`default_nettype none
module rth_div #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [rth_pkg::W-1:0] num,
   input  wire logic signed [rth_pkg::W-1:0] den,
   input  wire logic [SIDE_W-1:0]            side_i,
   output logic signed [rth_pkg::W-1:0]      quo,
   output logic [SIDE_W-1:0]                 side_o
);
   import rth_pkg::*;
   localparam int NB = W + FRAC_BITS;
   localparam int QB = 64 + FRAC_BITS;

   logic [NB-1:0] n_ff [0:NB];
   logic [W-1:0]  d_ff [0:NB];
   logic [W:0]    r_ff [0:NB];
   logic [QB-1:0] q_ff [0:NB];
   logic          neg_ff [0:NB];
   logic [SIDE_W-1:0] s_ff [0:NB];
   logic [W-1:0]  mn, md;
   logic signed [W-1:0] quo_ff, quo_in;

   always_comb begin
      mn = num[W-1] ? (~num + 64'd1) : num;
      md = den[W-1] ? (~den + 64'd1) : den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= {mn, {FRAC_BITS{1'b0}}};
         d_ff[0]   <= md;
         r_ff[0]   <= '0;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[W-1] ^ den[W-1];
         s_ff[0]   <= side_i;
      end
   end

   for (genvar i = 0; i < NB; i++) begin : g_step
      logic [W:0] r_sh;
      logic       ge;
      always_comb begin
         r_sh = {r_ff[i][W-1:0], n_ff[i][NB-1-i]};
         ge   = r_sh >= {1'b0, d_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i+1]   <= ge ? (r_sh - {1'b0, d_ff[i]}) : r_sh;
            q_ff[i+1]   <= {q_ff[i][QB-2:0], ge};
            n_ff[i+1]   <= n_ff[i];
            d_ff[i+1]   <= d_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            s_ff[i+1]   <= s_ff[i];
         end
      end
   end

   always_comb begin
      if (!neg_ff[NB])
         quo_in = (q_ff[NB][QB-1:63] != '0) ? SMAX : q_ff[NB][63:0];
      else
         quo_in = (q_ff[NB][QB-1:64] != '0 || q_ff[NB][63]) ? SMIN
                : (~q_ff[NB][63:0] + 64'd1);
   end

   logic [SIDE_W-1:0] so_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
         so_ff  <= s_ff[NB];
      end
   end
   assign quo    = quo_ff;
   assign side_o = so_ff;
endmodule
`default_nettype wire

@@ rtl/ray_triangle_hit_test.sv @@
// Top level of the ray/triangle hit test: config registers, deep pipeline of
// multipliers and dividers, output register. Uses rth_pkg, rth_mul, rth_div.
//
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tdata[287:0] a..c xyz
// rsp     | out | rsp_tvalid/tready   | tdata[7:0] hit, parallel
// csr     | in  | csr_valid/ready     | csr_index, csr_data
//
// One item per cycle sustained while rsp is not stalled; an accepted item passes
// through two dividers of W+FRAC_BITS+2 stages, four multiplier ranks and other
// registers before it is offered on rsp.
// Reset clears valid bits and loads the reset ray. Whole pipeline advances only
// when the output slot is free or taken, so a stall holds every stage.
`default_nettype none
module ray_triangle_hit_test #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [287:0] req_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,  // hit, parallel, zero fill
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import rth_pkg::*;
   localparam int DL = (W + FRAC_BITS) + 2;
   localparam int TD = 1 + 3 + 1 + 3 + 2 + DL;
   localparam int LAT = TD + 3 + 1 + 3 + 1 + DL + 1 + 1;
   localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

   ray_type ray_ff;
   logic    en;
   logic    vld_ff [0:LAT-1];
   logic    hit_ff, par_ff, ov_ff;

   function automatic logic signed [W-1:0] sx(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= ray_type'({{(5*W){1'b0}}, ONE});
      end else if (csr_valid) begin
         case (csr_index)
            REG_ORIGIN_X: ray_ff.ox <= sx(csr_data);
            REG_ORIGIN_Y: ray_ff.oy <= sx(csr_data);
            REG_ORIGIN_Z: ray_ff.oz <= sx(csr_data);
            REG_DIR_X:    ray_ff.dx <= sx(csr_data);
            REG_DIR_Y:    ray_ff.dy <= sx(csr_data);
            REG_DIR_Z:    ray_ff.dz <= sx(csr_data);
            default: ;
         endcase
      end
   end

   assign en         = !ov_ff || rsp_tready;
   assign req_tready = en;

   // vertex delay line so every stage sees the inputs it needs
   logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   assign ax = sx(req_tdata[31:0]);
   assign ay = sx(req_tdata[63:32]);
   assign az = sx(req_tdata[95:64]);
   assign bx = sx(req_tdata[127:96]);
   assign by = sx(req_tdata[159:128]);
   assign bz = sx(req_tdata[191:160]);
   assign cx = sx(req_tdata[223:192]);
   assign cy = sx(req_tdata[255:224]);
   assign cz = sx(req_tdata[287:256]);

   logic [287:0] vd_ff [0:TD+2];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         vd_ff[0] <= req_tdata;
         for (int i = 1; i < TD + 3; i++) vd_ff[i] <= vd_ff[i-1];
      end
   end

   function automatic logic signed [W-1:0] fx(logic [287:0] d, int k);
      return {{32{d[32*k+31]}}, d[32*k +: 32]};
   endfunction

   // stage A: edges and origin offsets
   logic signed [W-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [W-1:0] qx_ff, qy_ff, qz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         e1x_ff <= bx - ax; e1y_ff <= by - ay; e1z_ff <= bz - az;
         e2x_ff <= cx - bx; e2y_ff <= cy - by; e2z_ff <= cz - bz;
         qx_ff <= ssub(ax, ray_ff.ox);
         qy_ff <= ssub(ay, ray_ff.oy);
         qz_ff <= ssub(az, ray_ff.oz);
      end
   end

   // stage B: cross product terms
   logic signed [W-1:0] m [0:5];
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.clock, .en, .a(e1y_ff), .b(e2z_ff), .p(m[0]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clock, .en, .a(e1z_ff), .b(e2y_ff), .p(m[1]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clock, .en, .a(e1z_ff), .b(e2x_ff), .p(m[2]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clock, .en, .a(e1x_ff), .b(e2z_ff), .p(m[3]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.clock, .en, .a(e1x_ff), .b(e2y_ff), .p(m[4]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_m5 (.clock, .en, .a(e1y_ff), .b(e2x_ff), .p(m[5]));

   logic signed [W-1:0] q1x_ff, q1y_ff, q1z_ff, q2x_ff, q2y_ff, q2z_ff;
   logic signed [W-1:0] q3x_ff, q3y_ff, q3z_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         q1x_ff <= qx_ff; q1y_ff <= qy_ff; q1z_ff <= qz_ff;
         q2x_ff <= q1x_ff; q2y_ff <= q1y_ff; q2z_ff <= q1z_ff;
         q3x_ff <= q2x_ff; q3y_ff <= q2y_ff; q3z_ff <= q2z_ff;
      end
   end

   logic signed [W-1:0] nx_ff, ny_ff, nz_ff, oqx_ff, oqy_ff, oqz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= ssub(m[0], m[1]);
         ny_ff <= ssub(m[2], m[3]);
         nz_ff <= ssub(m[4], m[5]);
         oqx_ff <= q3x_ff; oqy_ff <= q3y_ff; oqz_ff <= q3z_ff;
      end
   end

   // stage C: dot products then sums
   logic signed [W-1:0] dn [0:2];
   logic signed [W-1:0] nm [0:2];
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_d0 (.clock, .en, .a(nx_ff), .b(ray_ff.dx), .p(dn[0]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_d1 (.clock, .en, .a(ny_ff), .b(ray_ff.dy), .p(dn[1]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_d2 (.clock, .en, .a(nz_ff), .b(ray_ff.dz), .p(dn[2]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_n0 (.clock, .en, .a(nx_ff), .b(oqx_ff), .p(nm[0]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_n1 (.clock, .en, .a(ny_ff), .b(oqy_ff), .p(nm[1]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_n2 (.clock, .en, .a(nz_ff), .b(oqz_ff), .p(nm[2]));

   logic signed [W-1:0] den1_ff, num1_ff, dn2_ff, nm2_ff, den_ff, num_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         den1_ff <= sadd(dn[0], dn[1]);
         num1_ff <= sadd(nm[0], nm[1]);
         dn2_ff  <= dn[2];
         nm2_ff  <= nm[2];
         den_ff  <= sadd(den1_ff, dn2_ff);
         num_ff  <= sadd(num1_ff, nm2_ff);
      end
   end

   // stage D: ray parameter
   logic signed [W-1:0] r_q;
   logic                par_d;
   logic                par_in;
   assign par_in = (den_ff == '0);
   rth_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_r (
      .clock, .en, .num(par_in ? '0 : num_ff), .den(par_in ? ONE : den_ff),
      .side_i(par_in), .quo(r_q), .side_o(par_d));

   // stage E: hit point, then weight numerators and divisor
   logic signed [W-1:0] pxm, pym;
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_px (.clock, .en, .a(r_q), .b(ray_ff.dx), .p(pxm));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_py (.clock, .en, .a(r_q), .b(ray_ff.dy), .p(pym));
   logic par_e_ff [0:2];
   always_ff @(posedge clock) begin
      if (en) begin
         par_e_ff[0] <= par_d;
         par_e_ff[1] <= par_e_ff[0];
         par_e_ff[2] <= par_e_ff[1];
      end
   end

   logic [287:0] ve;
   assign ve = vd_ff[TD+2];
   logic signed [W-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic par_f_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         v0x_ff <= ssub(sadd(ray_ff.ox, pxm), fx(ve, 6));
         v0y_ff <= ssub(sadd(ray_ff.oy, pym), fx(ve, 7));
         v1x_ff <= fx(ve, 0) - fx(ve, 6);
         v1y_ff <= fx(ve, 1) - fx(ve, 7);
         v2x_ff <= fx(ve, 3) - fx(ve, 6);
         v2y_ff <= fx(ve, 4) - fx(ve, 7);
         par_f_ff <= par_e_ff[2];
      end
   end

   logic signed [W-1:0] k [0:5];
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_k0 (.clock, .en, .a(v1x_ff), .b(v2y_ff), .p(k[0]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_k1 (.clock, .en, .a(v2x_ff), .b(v1y_ff), .p(k[1]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_k2 (.clock, .en, .a(v0x_ff), .b(v2y_ff), .p(k[2]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_k3 (.clock, .en, .a(v2x_ff), .b(v0y_ff), .p(k[3]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_k4 (.clock, .en, .a(v1x_ff), .b(v0y_ff), .p(k[4]));
   rth_mul #(.FRAC_BITS(FRAC_BITS)) u_k5 (.clock, .en, .a(v0x_ff), .b(v1y_ff), .p(k[5]));
   logic par_g_ff [0:2];
   always_ff @(posedge clock) begin
      if (en) begin
         par_g_ff[0] <= par_f_ff;
         par_g_ff[1] <= par_g_ff[0];
         par_g_ff[2] <= par_g_ff[1];
      end
   end

   logic signed [W-1:0] dd_ff, na_ff, nb_ff;
   logic par_h_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff <= ssub(k[0], k[1]);
         na_ff <= ssub(k[2], k[3]);
         nb_ff <= ssub(k[4], k[5]);
         par_h_ff <= par_g_ff[2];
      end
   end

   // stage F: weights
   logic signed [W-1:0] wa, wb;
   logic [1:0] sa, sb;
   logic dz;
   assign dz = (dd_ff == '0);
   rth_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div_a (
      .clock, .en, .num(dz ? '0 : na_ff), .den(dz ? ONE : dd_ff),
      .side_i({dz, par_h_ff}), .quo(wa), .side_o(sa));
   rth_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div_b (
      .clock, .en, .num(dz ? '0 : nb_ff), .den(dz ? ONE : dd_ff),
      .side_i({dz, par_h_ff}), .quo(wb), .side_o(sb));

   function automatic logic unit_ok(logic signed [W-1:0] w);
      return !w[W-1] && (w <= ONE);
   endfunction

   logic signed [W-1:0] wa_ff, wb_ff, wc_ff;
   logic [1:0] s1_ff, s2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wa_ff <= wa; wb_ff <= wb; s1_ff <= sa;
         wc_ff <= ssub(ONE, wa);
         s2_ff <= s1_ff;
      end
   end
   logic signed [W-1:0] wc2_ff;
   logic ok_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wc2_ff <= ssub(wc_ff, wb_ff);
         ok_ff  <= unit_ok(wa_ff) && unit_ok(wb_ff) && !s1_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (en) ov_ff <= vld_ff[LAT-1];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= ok_ff && unit_ok(wc2_ff);
         par_ff <= s2_ff[0];
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, par_ff, hit_ff};

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (!(rsp_tvalid && !rsp_tready) || !req_tready)
            else $error("pipeline advanced during output stall");
      end
   end
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result lost while stalled");
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("csr port blocked");
endmodule
`default_nettype wire

@@ test/ray_triangle_hit_test_checker.sv @@
// Checker for the ray/triangle hit test: watches the csr, req and rsp channels,
// predicts hit and parallel per triangle in 64-bit fixed point with 128-bit
// intermediates, compares results. Depends on rth_pkg.
module ray_triangle_hit_test_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [287:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           mismatches,
   output int           pending
);
   import rth_pkg::*;
   localparam int FB = 16;
   typedef logic signed [63:0] fx_t;

   fx_t org_x, org_y, org_z, dir_x, dir_y, dir_z;
   logic [1:0] expected_flags[$];

   function automatic fx_t clamp128(logic signed [127:0] v);
      if (v > 128'sd9223372036854775807) return SMAX;
      if (v < -128'sd9223372036854775808) return SMIN;
      return v[63:0];
   endfunction

   function automatic fx_t fx_mul(fx_t a, fx_t b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      // signed division truncates toward zero
      return clamp128(p / (128'sd1 <<< FB));
   endfunction

   function automatic fx_t fx_div(fx_t n, fx_t d);
      logic signed [127:0] q;
      q = (128'(n) <<< FB) / 128'(d);
      return clamp128(q);
   endfunction

   function automatic fx_t cross_term(fx_t x, fx_t y2, fx_t x2, fx_t y);
      return ssub(fx_mul(x, y2), fx_mul(x2, y));
   endfunction

   function automatic logic in_unit(fx_t w);
      return w >= 0 && w <= (64'sd1 <<< FB);
   endfunction

   function automatic logic [1:0] triangle_flags(logic [287:0] t);
      fx_t v[9];
      fx_t e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, den, num, r, px, py, d;
      fx_t wa, wb, wc;
      logic par, hit;
      for (int i = 0; i < 9; i++) v[i] = fx_t'($signed(t[32*i +: 32]));
      e1x = v[3] - v[0]; e1y = v[4] - v[1]; e1z = v[5] - v[2];
      e2x = v[6] - v[3]; e2y = v[7] - v[4]; e2z = v[8] - v[5];
      nx = cross_term(e1y, e2z, e1z, e2y);
      ny = cross_term(e1z, e2x, e1x, e2z);
      nz = cross_term(e1x, e2y, e1y, e2x);
      den = sadd(sadd(fx_mul(nx, dir_x), fx_mul(ny, dir_y)), fx_mul(nz, dir_z));
      num = sadd(sadd(fx_mul(nx, ssub(v[0], org_x)), fx_mul(ny, ssub(v[1], org_y))),
                 fx_mul(nz, ssub(v[2], org_z)));
      par = (den == 0);
      r = par ? 64'sd0 : fx_div(num, den);
      px = sadd(org_x, fx_mul(r, dir_x));
      py = sadd(org_y, fx_mul(r, dir_y));
      d = cross_term(v[0] - v[6], v[4] - v[7], v[3] - v[6], v[1] - v[7]);
      hit = 1'b0;
      if (d != 0) begin
         wa = fx_div(cross_term(ssub(px, v[6]), v[4] - v[7], v[3] - v[6],
                                ssub(py, v[7])), d);
         wb = fx_div(cross_term(v[0] - v[6], ssub(py, v[7]), ssub(px, v[6]),
                                v[1] - v[7]), d);
         wc = ssub(ssub(64'sd1 <<< FB, wa), wb);
         hit = in_unit(wa) && in_unit(wb) && in_unit(wc);
      end
      return {par, hit};
   endfunction

   assign pending = expected_flags.size();

   always_ff @(posedge clock) begin
      logic [1:0] want;
      fx_t v;
      if (reset) begin
         org_x <= 0; org_y <= 0; org_z <= 0;
         dir_x <= 0; dir_y <= 0; dir_z <= 64'sd1 <<< FB;
         mismatches <= 0;
         expected_flags.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            v = fx_t'($signed(csr_data));
            case (reg_index_type'(csr_index))
               REG_ORIGIN_X: org_x <= v;
               REG_ORIGIN_Y: org_y <= v;
               REG_ORIGIN_Z: org_z <= v;
               REG_DIR_X:    dir_x <= v;
               REG_DIR_Y:    dir_y <= v;
               REG_DIR_Z:    dir_z <= v;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_flags.push_back(triangle_flags(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_flags.size() == 0) begin
               if (mismatches < 10) $display("unexpected item %h", rsp_tdata);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_flags.pop_front();
               if (rsp_tdata != {6'd0, want}) begin
                  if (mismatches < 10)
                     $display("mismatch: hit exp %b got %b, parallel exp %b got %b",
                              want[0], rsp_tdata[0], want[1], rsp_tdata[1]);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule

@@ test/ray_triangle_hit_test_test.sv @@
// Testbench top for ray_triangle_hit_test: clock, reset, csr writes, triangle
// stimulus and rsp back-pressure. Uses rth_pkg and ray_triangle_hit_test_checker.
module ray_triangle_hit_test_test;
   import rth_pkg::*;
   localparam int ONE = 65536;
   localparam int DRAIN = 400;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [287:0] req_tdata = '0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [7:0] rsp_tdata;
   int mismatches, pending;
   int cycles = 0;
   logic hold_rsp = 0;

   ray_triangle_hit_test DUT (.*);
   ray_triangle_hit_test_checker watch (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("ray_triangle_hit_test_test NOT OK");
         $finish;
      end
   end

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stalls at random; hold_rsp forces a long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 99) < 70);
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIR_X, dx);
      write_reg(REG_DIR_Y, dy);    write_reg(REG_DIR_Z, dz);
      csr_valid <= 0;
   endtask

   // valid stays high after an accept; the next call drops it only for a gap, drain() drops it
   task automatic send_triangle(logic [287:0] t, bit may_gap);
      int g;
      g = may_gap ? gap_len() : 0;
      if (g != 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= t;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [287:0] tri9(int ax, int ay, int az, int bx, int by,
                                         int bz, int cx, int cy, int cz);
      return {cz, cy, cx, bz, by, bx, az, ay, ax};
   endfunction

   function automatic int small_coord();
      return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
   endfunction

   function automatic logic [287:0] random_triangle();
      logic [287:0] t;
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) begin
         for (int i = 0; i < 9; i++) t[32*i +: 32] = small_coord();
      end else if (k < 8) begin
         // triangle around the z axis so many rays hit
         t = tri9(-$urandom_range(1, 4*ONE), -$urandom_range(1, 4*ONE), small_coord(),
                  $urandom_range(1, 4*ONE), -$urandom_range(1, 4*ONE), small_coord(),
                  small_coord() / 4, $urandom_range(1, 4*ONE), small_coord());
      end else begin
         for (int i = 0; i < 9; i++) t[32*i +: 32] = $urandom;
      end
      return t;
   endfunction

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // default ray straight up z; directed cases
      send_triangle(tri9(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE), 1);
      send_triangle(tri9(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0), 1);
      send_triangle(tri9(2*ONE, 2*ONE, 0, 3*ONE, 2*ONE, 0, 2*ONE, 3*ONE, 0), 1);
      send_triangle(tri9(0, 0, 0, ONE, 0, ONE, 2*ONE, 0, 2*ONE), 1);
      send_triangle(tri9(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1);
      send_triangle(tri9(0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1);
      send_triangle({9{32'h7fffffff}}, 1);
      send_triangle({9{32'h80000000}}, 1);
      send_triangle(tri9(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 0, 32'h7fffffff, 0), 1);
      send_triangle({9{32'hffffffff}}, 1);
      drain();
      set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000);
      send_triangle(tri9(0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1);
      send_triangle({9{32'h55555555}}, 1);
      send_triangle({9{32'haaaaaaaa}}, 1);
      drain();
      set_ray(0, 0, 0, 0, 0, 0);
      send_triangle(tri9(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE), 1);
      send_triangle(tri9(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0), 1);
      drain();
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4)
            set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            set_ray(small_coord()/8, small_coord()/8, -5*ONE,
                    small_coord()/16, small_coord()/16, $urandom_range(ONE/2, 2*ONE));
         if (phase == 1) begin
            // long receiver hold-off while items keep coming, more than the
            // pipeline holds so the input stalls
            fork
               begin
                  hold_rsp <= 1;
                  repeat (600) @(posedge clock);
                  hold_rsp <= 0;
               end
               for (int i = 0; i < 250; i++) send_triangle(random_triangle(), 0);
            join
         end else begin
            for (int i = 0; i < 120; i++)
               send_triangle(random_triangle(), $urandom_range(0, 3) != 0);
         end
         drain();
      end
      if (mismatches == 0) $display("ray_triangle_hit_test_test OK");
      else $display("ray_triangle_hit_test_test NOT OK");
      $finish;
   end
endmodule

@@ ray_triangle_hit_test.f @@
rtl/rth_pkg.sv
rtl/rth_mul.sv
rtl/rth_div.sv
rtl/ray_triangle_hit_test.sv
test/ray_triangle_hit_test_checker.sv
test/ray_triangle_hit_test_test.sv
